// ===== src/ocp_pkg.sv =====
// shared types, constants and helpers for the orbit camera block
`default_nettype none
package ocp_pkg;

   // 256 turns of 360 degrees in Q16.16, added to lift any angle above zero
   localparam logic [33:0] TURN_OFFSET = 34'd6039797760;

   // floor(h / 45) for h below 2^15 is (h * RECIP_45) >> 21
   localparam logic [15:0] RECIP_45 = 16'd46604;
   localparam logic [14:0] MOD_45   = 15'd45;

   // ceil(2^43 / 45) split at bit 19: floor(t * 2^13 / 45) is (t * mul) >> 30
   localparam logic [18:0] BANG_MUL_HI = 19'd372827;
   localparam logic [18:0] BANG_MUL_LO = 19'd11651;

   localparam logic signed [13:0] PITCH_GAIN  = 14'sd6554;
   localparam logic signed [15:0] ORBIT_GAIN  = 16'sd19661;
   localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
   localparam int                 CORDIC_STEPS = 30;

   localparam logic signed [23:0] PITCH_FLOOR_RESET = 24'sd0;
   localparam logic signed [23:0] PITCH_CEIL_RESET  = 24'sd5898240;
   localparam logic [30:0]        DISTANCE_RESET    = 31'd3276800;

   localparam logic [1:0] CSR_PITCH_FLOOR = 2'd0;
   localparam logic [1:0] CSR_PITCH_CEIL  = 2'd1;
   localparam logic [1:0] CSR_DISTANCE    = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL,
      ST_PITCH,
      ST_ORB_WAIT,
      ST_PANG,
      ST_PANG_WAIT,
      ST_PCOR_WAIT,
      ST_VANG,
      ST_VANG_WAIT,
      ST_VCOR_WAIT,
      ST_CAM,
      ST_RSP
   } state_type;

   typedef enum logic [1:0] {
      ANG_ORBIT,
      ANG_PITCH,
      ANG_VIEW
   } ang_src_type;

   typedef struct packed {
      logic        capture;
      logic        mul;
      logic        pitch_upd;
      logic        ang_start;
      ang_src_type ang_src;
      logic        orbit_store;
      logic        cordic_start;
      logic        dist_mul;
      logic        off_mul;
      logic        out_load;
   } cmd_type;

   typedef struct packed {
      logic ang_done;
      logic cordic_done;
   } status_type;

   // arctangent of 2^-i as a binary angle, 2^32 per turn
   function automatic logic [29:0] arc_angle(input logic [4:0] i);
      logic [29:0] a;
      case (i)
         5'd0:  a = 30'h20000000;
         5'd1:  a = 30'h12E4051E;
         5'd2:  a = 30'h09FB385B;
         5'd3:  a = 30'h051111D4;
         5'd4:  a = 30'h028B0D43;
         5'd5:  a = 30'h0145D7E1;
         5'd6:  a = 30'h00A2F61E;
         5'd7:  a = 30'h00517C55;
         5'd8:  a = 30'h0028BE53;
         5'd9:  a = 30'h00145F2F;
         5'd10: a = 30'h000A2F98;
         5'd11: a = 30'h000517CC;
         5'd12: a = 30'h00028BE6;
         5'd13: a = 30'h000145F3;
         5'd14: a = 30'h0000A2FA;
         5'd15: a = 30'h0000517D;
         5'd16: a = 30'h000028BE;
         5'd17: a = 30'h0000145F;
         5'd18: a = 30'h00000A30;
         5'd19: a = 30'h00000518;
         5'd20: a = 30'h0000028C;
         5'd21: a = 30'h00000146;
         5'd22: a = 30'h000000A3;
         5'd23: a = 30'h00000051;
         5'd24: a = 30'h00000029;
         5'd25: a = 30'h00000014;
         5'd26: a = 30'h0000000A;
         5'd27: a = 30'h00000005;
         5'd28: a = 30'h00000003;
         5'd29: a = 30'h00000001;
         default: a = 30'h0;
      endcase
      return a;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
      logic signed [31:0] r;
      if (v > 36'sd2147483647) begin
         r = 32'sh7FFFFFFF;
      end else if (v < -36'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// ===== src/orbit_camera_position.sv =====
// top level of the third-person orbit camera position block
//
//   port group  direction  handshake         contents
//   req_*       in         valid / stall     drag flag, mouse deltas, object yaw and position
//   rsp_*       out        valid / stall     camera position, horizontal offsets
//   csr_*       in         write enable      pitch floor, pitch ceiling, follow distance
//
// one request at a time; the next request is accepted only after the result is taken:
// the angle unit takes 2 steps for the orbit wrap and 4 for each of the two trig angles,
// the cordic 30 steps for each sine/cosine pair
// reset is synchronous; it clears pitch, orbit angle and the settings to their defaults
// req_stall is high from acceptance until the result is taken; a stalled result holds
`default_nettype none
module orbit_camera_position (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic               req_drag_active,
   input  wire logic signed [15:0] req_mouse_dx,
   input  wire logic signed [15:0] req_mouse_dy,
   input  wire logic signed [31:0] req_object_yaw,
   input  wire logic signed [31:0] req_object_x,
   input  wire logic signed [31:0] req_object_y,
   input  wire logic signed [31:0] req_object_z,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic signed [31:0]      rsp_camera_x,
   output logic signed [31:0]      rsp_camera_y,
   output logic signed [31:0]      rsp_camera_z,
   output logic signed [31:0]      rsp_offset_x,
   output logic signed [31:0]      rsp_offset_z,
   input  wire logic               csr_write,
   input  wire logic [1:0]         csr_index,
   input  wire logic [30:0]        csr_wdata
);
   import ocp_pkg::*;

   cmd_type    cmd;
   status_type status;

   ocp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   ocp_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_drag_active (req_drag_active),
      .req_mouse_dx    (req_mouse_dx),
      .req_mouse_dy    (req_mouse_dy),
      .req_object_yaw  (req_object_yaw),
      .req_object_x    (req_object_x),
      .req_object_y    (req_object_y),
      .req_object_z    (req_object_z),
      .rsp_camera_x    (rsp_camera_x),
      .rsp_camera_y    (rsp_camera_y),
      .rsp_camera_z    (rsp_camera_z),
      .rsp_offset_x    (rsp_offset_x),
      .rsp_offset_z    (rsp_offset_z)
   );

endmodule
`default_nettype wire

// ===== src/ocp_angle.sv =====
// angle reduction modulo 360 degrees and conversion to a binary angle
`default_nettype none
module ocp_angle (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic               frac,
   input  wire logic signed [32:0] angle,
   output logic                    done,
   output logic [24:0]             rem,
   output logic [31:0]             bang
);
   import ocp_pkg::*;

   logic [33:0] a_ff, a_in;
   logic [9:0]  q_ff, q_in;
   logic [24:0] t_ff, t_in;
   logic [43:0] phi_ff, phi_in;
   logic [43:0] plo_ff, plo_in;
   logic [31:0] bang_ff, bang_in;
   logic [1:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        frac_ff, frac_in;
   logic        done_ff, done_in;

   logic [30:0] qprod;
   logic [14:0] qmul;
   logic [14:0] hi_rem;
   logic [62:0] psum;
   logic        last;

   always_comb begin
      // 360 degrees is 45 * 2^19, so only the bits above bit 18 need a mod 45
      qprod   = 31'(a_ff[33:19]) * 31'(RECIP_45);
      qmul    = 15'(q_ff) * MOD_45;
      hi_rem  = a_ff[33:19] - qmul;
      psum    = {phi_ff, 19'd0} + {19'd0, plo_ff};
      last    = frac_ff ? (cnt_ff == 2'd3) : (cnt_ff == 2'd1);
      a_in    = a_ff;
      q_in    = q_ff;
      t_in    = t_ff;
      phi_in  = phi_ff;
      plo_in  = plo_ff;
      bang_in = bang_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      frac_in = frac_ff;
      done_in = 1'b0;
      if (start) begin
         a_in    = {angle[32], angle} + TURN_OFFSET;
         cnt_in  = 2'd0;
         busy_in = 1'b1;
         frac_in = frac;
      end else if (busy_ff) begin
         // one stage per cycle: quotient, remainder, products, binary angle; with frac low it stops after the remainder
         q_in    = qprod[30:21];
         t_in    = {hi_rem[5:0], a_ff[18:0]};
         phi_in  = 44'(t_ff) * 44'(BANG_MUL_HI);
         plo_in  = 44'(t_ff) * 44'(BANG_MUL_LO);
         bang_in = psum[61:30];
         cnt_in  = cnt_ff + 2'd1;
         if (last) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 2'd0;
         frac_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
         frac_ff <= frac_in;
      end
      a_ff    <= a_in;
      q_ff    <= q_in;
      t_ff    <= t_in;
      phi_ff  <= phi_in;
      plo_ff  <= plo_in;
      bang_ff <= bang_in;
   end

   assign done = done_ff;
   assign rem  = t_ff;
   assign bang = bang_ff;

endmodule
`default_nettype wire

// ===== src/ocp_cordic.sv =====
// iterative rotation cordic giving sine and cosine of a binary angle
`default_nettype none
module ocp_cordic (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [31:0] bang,
   output logic             done,
   output logic signed [31:0] sin_val,
   output logic signed [31:0] cos_val
);
   import ocp_pkg::*;

   logic signed [33:0] x_ff, x_in, y_ff, y_in;
   logic signed [32:0] z_ff, z_in;
   logic [1:0]         quad_ff, quad_in;
   logic [4:0]         cnt_ff, cnt_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;

   logic signed [33:0] dx, dy;
   logic signed [32:0] arc;
   logic signed [33:0] c_full, s_full;

   always_comb begin
      dx  = y_ff >>> cnt_ff;
      dy  = x_ff >>> cnt_ff;
      arc = $signed({3'b000, arc_angle(cnt_ff)});
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      quad_in = quad_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         x_in    = CORDIC_GAIN;
         y_in    = 34'sd0;
         z_in    = $signed({3'b000, bang[29:0]});
         quad_in = bang[31:30];
         cnt_in  = 5'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!z_ff[32]) begin
            x_in = x_ff - dx;
            y_in = y_ff + dy;
            z_in = z_ff - arc;
         end else begin
            x_in = x_ff + dx;
            y_in = y_ff - dy;
            z_in = z_ff + arc;
         end
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'(CORDIC_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 5'd0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      quad_ff <= quad_in;
   end

   // quadrant folding
   always_comb begin
      case (quad_ff)
         2'd0: begin
            c_full = x_ff;
            s_full = y_ff;
         end
         2'd1: begin
            c_full = -y_ff;
            s_full = x_ff;
         end
         2'd2: begin
            c_full = -x_ff;
            s_full = -y_ff;
         end
         default: begin
            c_full = y_ff;
            s_full = -x_ff;
         end
      endcase
   end

   assign done    = done_ff;
   assign cos_val = c_full[31:0];
   assign sin_val = s_full[31:0];

endmodule
`default_nettype wire

// ===== src/ocp_dp.sv =====
// datapath: settings, view angles, products and the result registers
`default_nettype none
module ocp_dp (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire ocp_pkg::cmd_type    cmd,
   output ocp_pkg::status_type      status,
   input  wire logic                csr_write,
   input  wire logic [1:0]          csr_index,
   input  wire logic [30:0]         csr_wdata,
   input  wire logic                req_drag_active,
   input  wire logic signed [15:0]  req_mouse_dx,
   input  wire logic signed [15:0]  req_mouse_dy,
   input  wire logic signed [31:0]  req_object_yaw,
   input  wire logic signed [31:0]  req_object_x,
   input  wire logic signed [31:0]  req_object_y,
   input  wire logic signed [31:0]  req_object_z,
   output logic signed [31:0]       rsp_camera_x,
   output logic signed [31:0]       rsp_camera_y,
   output logic signed [31:0]       rsp_camera_z,
   output logic signed [31:0]       rsp_offset_x,
   output logic signed [31:0]       rsp_offset_z
);
   import ocp_pkg::*;

   logic signed [23:0] pitch_floor_ff, pitch_ceil_ff;
   logic [30:0]        distance_ff;
   logic signed [23:0] pitch_ff;
   logic [24:0]        orbit_ff;

   logic               drag_ff;
   logic signed [15:0] dx_ff, dy_ff;
   logic signed [31:0] yaw_ff, ox_ff, oy_ff, oz_ff;
   logic signed [28:0] dyprod_ff;
   logic signed [30:0] dxprod_ff;
   logic signed [33:0] hd_ff, vd_ff;
   logic signed [31:0] offx_ff, offz_ff;
   logic signed [31:0] camx_ff, camy_ff, camz_ff;

   logic signed [28:0] dyprod_in;
   logic signed [30:0] dxprod_in;
   logic signed [31:0] pitch_raw, pitch_lo, pitch_hi, pitch_in;
   logic signed [32:0] ang_in;
   logic               ang_frac;
   logic               ang_done, cordic_done;
   logic [24:0]        ang_rem;
   logic [31:0]        ang_bang;
   logic signed [31:0] sin_val, cos_val;
   logic signed [63:0] hprod, vprod;
   logic signed [65:0] xprod, zprod;

   assign dyprod_in = dy_ff * PITCH_GAIN;
   assign dxprod_in = dx_ff * ORBIT_GAIN;

   // min test wins when the limits are crossed
   always_comb begin
      pitch_raw = {{8{pitch_ff[23]}}, pitch_ff} - {{3{dyprod_ff[28]}}, dyprod_ff};
      pitch_lo  = {{8{pitch_floor_ff[23]}}, pitch_floor_ff};
      pitch_hi  = {{8{pitch_ceil_ff[23]}}, pitch_ceil_ff};
      if (pitch_raw < pitch_lo) begin
         pitch_in = pitch_lo;
      end else if (pitch_raw > pitch_hi) begin
         pitch_in = pitch_hi;
      end else begin
         pitch_in = pitch_raw;
      end
   end

   always_comb begin
      case (cmd.ang_src)
         ANG_ORBIT: begin
            if (drag_ff) begin
               ang_in = $signed({8'b0, orbit_ff}) - {{2{dxprod_ff[30]}}, dxprod_ff};
            end else begin
               ang_in = $signed({8'b0, orbit_ff});
            end
         end
         ANG_PITCH: ang_in = {{9{pitch_ff[23]}}, pitch_ff};
         ANG_VIEW:  ang_in = {yaw_ff[31], yaw_ff} + $signed({8'b0, orbit_ff});
         default:   ang_in = 33'sd0;
      endcase
      ang_frac = (cmd.ang_src != ANG_ORBIT);
   end

   ocp_angle u_angle (
      .clock (clock),
      .reset (reset),
      .start (cmd.ang_start),
      .frac  (ang_frac),
      .angle (ang_in),
      .done  (ang_done),
      .rem   (ang_rem),
      .bang  (ang_bang)
   );

   ocp_cordic u_cordic (
      .clock   (clock),
      .reset   (reset),
      .start   (cmd.cordic_start),
      .bang    (ang_bang),
      .done    (cordic_done),
      .sin_val (sin_val),
      .cos_val (cos_val)
   );

   assign status.ang_done    = ang_done;
   assign status.cordic_done = cordic_done;

   assign hprod = $signed({1'b0, distance_ff}) * cos_val;
   assign vprod = $signed({1'b0, distance_ff}) * sin_val;
   assign xprod = hd_ff * sin_val;
   assign zprod = hd_ff * cos_val;

   always_ff @(posedge clock) begin
      if (reset) begin
         pitch_floor_ff <= PITCH_FLOOR_RESET;
         pitch_ceil_ff  <= PITCH_CEIL_RESET;
         distance_ff    <= DISTANCE_RESET;
         pitch_ff       <= 24'sd0;
         orbit_ff       <= 25'd0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_PITCH_FLOOR: pitch_floor_ff <= csr_wdata[23:0];
               CSR_PITCH_CEIL:  pitch_ceil_ff  <= csr_wdata[23:0];
               CSR_DISTANCE:    distance_ff    <= csr_wdata;
               default: ;
            endcase
         end
         if (cmd.pitch_upd && drag_ff) begin
            pitch_ff <= pitch_in[23:0];
         end
         if (cmd.orbit_store) begin
            orbit_ff <= ang_rem;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         drag_ff <= req_drag_active;
         dx_ff   <= req_mouse_dx;
         dy_ff   <= req_mouse_dy;
         yaw_ff  <= req_object_yaw;
         ox_ff   <= req_object_x;
         oy_ff   <= req_object_y;
         oz_ff   <= req_object_z;
      end
      if (cmd.mul) begin
         dyprod_ff <= dyprod_in;
         dxprod_ff <= dxprod_in;
      end
      if (cmd.dist_mul) begin
         hd_ff <= hprod[63:30];
         vd_ff <= vprod[63:30];
      end
      if (cmd.off_mul) begin
         offx_ff <= sat32(xprod[65:30]);
         offz_ff <= sat32(zprod[65:30]);
      end
      if (cmd.out_load) begin
         camx_ff <= sat32({{4{ox_ff[31]}}, ox_ff} - {{4{offx_ff[31]}}, offx_ff});
         camy_ff <= sat32({{4{oy_ff[31]}}, oy_ff} + {{2{vd_ff[33]}}, vd_ff});
         camz_ff <= sat32({{4{oz_ff[31]}}, oz_ff} - {{4{offz_ff[31]}}, offz_ff});
      end
   end

   assign rsp_camera_x = camx_ff;
   assign rsp_camera_y = camy_ff;
   assign rsp_camera_z = camz_ff;
   assign rsp_offset_x = offx_ff;
   assign rsp_offset_z = offz_ff;

endmodule
`default_nettype wire

// ===== src/ocp_ctrl.sv =====
// controller: sequences one request through the datapath
`default_nettype none
module ocp_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output ocp_pkg::cmd_type         cmd,
   input  wire ocp_pkg::status_type status
);
   import ocp_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.ang_src = ANG_ORBIT;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_PITCH;
         end
         ST_PITCH: begin
            cmd.pitch_upd = 1'b1;
            cmd.ang_start = 1'b1;
            cmd.ang_src   = ANG_ORBIT;
            state_in      = ST_ORB_WAIT;
         end
         ST_ORB_WAIT: begin
            if (status.ang_done) begin
               cmd.orbit_store = 1'b1;
               state_in        = ST_PANG;
            end
         end
         ST_PANG: begin
            cmd.ang_start = 1'b1;
            cmd.ang_src   = ANG_PITCH;
            state_in      = ST_PANG_WAIT;
         end
         ST_PANG_WAIT: begin
            if (status.ang_done) begin
               cmd.cordic_start = 1'b1;
               state_in         = ST_PCOR_WAIT;
            end
         end
         ST_PCOR_WAIT: begin
            if (status.cordic_done) begin
               cmd.dist_mul = 1'b1;
               state_in     = ST_VANG;
            end
         end
         ST_VANG: begin
            cmd.ang_start = 1'b1;
            cmd.ang_src   = ANG_VIEW;
            state_in      = ST_VANG_WAIT;
         end
         ST_VANG_WAIT: begin
            if (status.ang_done) begin
               cmd.cordic_start = 1'b1;
               state_in         = ST_VCOR_WAIT;
            end
         end
         ST_VCOR_WAIT: begin
            if (status.cordic_done) begin
               cmd.off_mul = 1'b1;
               state_in    = ST_CAM;
            end
         end
         ST_CAM: begin
            cmd.out_load = 1'b1;
            state_in     = ST_RSP;
         end
         ST_RSP: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

`ifndef SYNTHESIS
   a_ang_done_waited: assert property (@(posedge clock) disable iff (reset)
      status.ang_done |-> (state_ff == ST_ORB_WAIT || state_ff == ST_PANG_WAIT ||
                           state_ff == ST_VANG_WAIT))
      else $error("angle unit finished outside a wait state");
   a_cordic_done_waited: assert property (@(posedge clock) disable iff (reset)
      status.cordic_done |-> (state_ff == ST_PCOR_WAIT || state_ff == ST_VCOR_WAIT))
      else $error("cordic finished outside a wait state");
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == ST_MUL))
      else $error("accepted request did not start");
   a_single_start: assert property (@(posedge clock) disable iff (reset)
      !(cmd.ang_start && cmd.cordic_start))
      else $error("angle unit and cordic started together");
`endif

endmodule
`default_nettype wire

// ===== sim/tb_orbit_camera_position.sv =====
// self-checking testbench for the orbit camera position block
`default_nettype none
module tb_orbit_camera_position;
   import ocp_pkg::*;

   typedef struct {
      logic               drag;
      logic signed [15:0] dx;
      logic signed [15:0] dy;
      logic signed [31:0] yaw;
      logic signed [31:0] ox;
      logic signed [31:0] oy;
      logic signed [31:0] oz;
   } frame_type;

   typedef struct {
      logic signed [31:0] cam_x;
      logic signed [31:0] cam_y;
      logic signed [31:0] cam_z;
      logic signed [31:0] off_x;
      logic signed [31:0] off_z;
   } view_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic               req_drag_active = 1'b0;
   logic signed [15:0] req_mouse_dx = '0;
   logic signed [15:0] req_mouse_dy = '0;
   logic signed [31:0] req_object_yaw = '0;
   logic signed [31:0] req_object_x = '0;
   logic signed [31:0] req_object_y = '0;
   logic signed [31:0] req_object_z = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [31:0] rsp_camera_x;
   logic signed [31:0] rsp_camera_y;
   logic signed [31:0] rsp_camera_z;
   logic signed [31:0] rsp_offset_x;
   logic signed [31:0] rsp_offset_z;
   logic               csr_write = 1'b0;
   logic [1:0]         csr_index = CSR_PITCH_FLOOR;
   logic [30:0]        csr_wdata = '0;

   frame_type pending_frames[$];
   view_type  expected_views[$];
   int     send_idle_pct = 0;
   int     recv_stall_pct = 0;
   int     errors = 0;
   int     views_checked = 0;

   // predictor state and settings
   longint lim_lo, lim_hi, distance, pitch_deg, orbit_deg;

   localparam longint FULL_TURN = 64'sd23592960;
   localparam longint MAX32 = 64'sd2147483647;
   localparam longint MIN32 = -64'sd2147483648;

   orbit_camera_position u_dut (.*);

   always #4 clock = ~clock;

   function automatic longint wrap_turn(longint a);
      longint r;
      r = a % FULL_TURN;
      if (r < 0) r += FULL_TURN;
      return r;
   endfunction

   function automatic longint clip32(longint v);
      if (v > MAX32) return MAX32;
      if (v < MIN32) return MIN32;
      return v;
   endfunction

   function automatic void sin_cos(longint deg, output longint s, output longint c);
      logic [31:0] bang;
      longint x, y, z, tx, ty;
      bang = 32'((wrap_turn(deg) * 65536) / 360);
      z = longint'(bang[29:0]);
      x = 64'sd652032874;
      y = 0;
      for (int i = 0; i < 30; i++) begin
         tx = y >>> i;
         ty = x >>> i;
         if (z >= 0) begin
            x -= tx; y += ty; z -= longint'(arc_angle(5'(i)));
         end else begin
            x += tx; y -= ty; z += longint'(arc_angle(5'(i)));
         end
      end
      case (bang[31:30])
         2'd0: begin c = x;  s = y;  end
         2'd1: begin c = -y; s = x;  end
         2'd2: begin c = -x; s = -y; end
         default: begin c = y; s = -x; end
      endcase
   endfunction

   function automatic view_type camera_view(frame_type f);
      view_type v;
      longint p, sp, cp, st, ct, hd, vd, offx, offz;
      if (f.drag) begin
         p = pitch_deg - longint'(f.dy) * 6554;
         if (p < lim_lo) p = lim_lo;
         else if (p > lim_hi) p = lim_hi;
         pitch_deg = p;
         orbit_deg = wrap_turn(orbit_deg - longint'(f.dx) * 19661);
      end
      sin_cos(pitch_deg, sp, cp);
      hd = (distance * cp) >>> 30;
      vd = (distance * sp) >>> 30;
      sin_cos(longint'(f.yaw) + orbit_deg, st, ct);
      offx = clip32((hd * st) >>> 30);
      offz = clip32((hd * ct) >>> 30);
      v.cam_x = 32'(clip32(longint'(f.ox) - offx));
      v.cam_y = 32'(clip32(longint'(f.oy) + vd));
      v.cam_z = 32'(clip32(longint'(f.oz) - offz));
      v.off_x = 32'(offx);
      v.off_z = 32'(offz);
      return v;
   endfunction

   // driver: requests from the pending queue, predicted on acceptance
   always @(posedge clock) begin
      frame_type f;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (req_valid) begin
            f.drag = req_drag_active; f.dx = req_mouse_dx; f.dy = req_mouse_dy;
            f.yaw = req_object_yaw; f.ox = req_object_x; f.oy = req_object_y;
            f.oz = req_object_z;
            expected_views.push_back(camera_view(f));
         end
         if (pending_frames.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            f = pending_frames.pop_front();
            req_valid <= 1'b1;
            req_drag_active <= f.drag;
            req_mouse_dx <= f.dx;
            req_mouse_dy <= f.dy;
            req_object_yaw <= f.yaw;
            req_object_x <= f.ox;
            req_object_y <= f.oy;
            req_object_z <= f.oz;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   // monitor
   always @(posedge clock) begin
      view_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_views.size() == 0) begin
            $display("%0t: result with nothing expected, cam %0d %0d %0d", $realtime,
                     rsp_camera_x, rsp_camera_y, rsp_camera_z);
            errors++;
         end else begin
            e = expected_views.pop_front();
            views_checked++;
            if (rsp_camera_x !== e.cam_x) begin
               $display("%0t: camera_x expected %0d actual %0d", $realtime, e.cam_x, rsp_camera_x);
               errors++;
            end
            if (rsp_camera_y !== e.cam_y) begin
               $display("%0t: camera_y expected %0d actual %0d", $realtime, e.cam_y, rsp_camera_y);
               errors++;
            end
            if (rsp_camera_z !== e.cam_z) begin
               $display("%0t: camera_z expected %0d actual %0d", $realtime, e.cam_z, rsp_camera_z);
               errors++;
            end
            if (rsp_offset_x !== e.off_x) begin
               $display("%0t: offset_x expected %0d actual %0d", $realtime, e.off_x, rsp_offset_x);
               errors++;
            end
            if (rsp_offset_z !== e.off_z) begin
               $display("%0t: offset_z expected %0d actual %0d", $realtime, e.off_z, rsp_offset_z);
               errors++;
            end
         end
      end
   end

   task automatic write_reg(logic [1:0] idx, logic [30:0] val);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_PITCH_FLOOR: lim_lo = longint'($signed(val[23:0]));
         CSR_PITCH_CEIL:  lim_hi = longint'($signed(val[23:0]));
         CSR_DISTANCE:    distance = longint'(val);
         default: ;
      endcase
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic drain();
      while (pending_frames.size() > 0 || req_valid || expected_views.size() > 0)
         @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic add_frame(logic drag, logic [15:0] dx, logic [15:0] dy, logic [31:0] yaw,
                            logic [31:0] ox, logic [31:0] oy, logic [31:0] oz);
      frame_type f;
      f.drag = drag; f.dx = dx; f.dy = dy; f.yaw = yaw; f.ox = ox; f.oy = oy; f.oz = oz;
      pending_frames.push_back(f);
   endtask

   function automatic logic [31:0] rand_pos();
      case ($urandom_range(3))
         0: return $urandom();
         1: return $urandom_range(1) ? 32'h7FFF_FFF0 + $urandom_range(15)
                                     : 32'h8000_0000 + $urandom_range(15);
         default: return 32'($signed($urandom_range(2000000)) - 1000000);
      endcase
   endfunction

   function automatic logic [15:0] rand_delta();
      if ($urandom_range(3) == 0) return 16'($urandom());
      return 16'($signed($urandom_range(200)) - 100);
   endfunction

   function automatic logic [23:0] rand_pitch();
      return 24'($signed($urandom_range(11796480)) - 5898240);
   endfunction

   initial begin
      lim_lo = 0; lim_hi = 5898240; distance = 3276800; pitch_deg = 0; orbit_deg = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: reset settings, no drag, delta and position extremes
      add_frame(1'b0, 16'sd0, 16'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0);
      add_frame(1'b0, 16'sh7FFF, 16'sh8000, 32'sh7FFFFFFF, 32'sd100, 32'sd200, 32'sd300);
      add_frame(1'b1, 16'sd0, -16'sd100, 32'sd0, 32'sd0, 32'sd0, 32'sd0);
      add_frame(1'b1, 16'sh8000, 16'sh8000, 32'sh80000000, 32'sd0, 32'sd0, 32'sd0);
      add_frame(1'b1, 16'sh7FFF, 16'sh7FFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
                32'sh7FFFFFFF);
      add_frame(1'b1, 16'sd1200, -16'sd450, 32'sh80000000, 32'sh80000000, 32'sh80000000,
                32'sh80000000);
      add_frame(1'b1, -16'sd1, 16'sd1, 32'd23592960, 32'sd1, -32'sd1, 32'sd1);
      add_frame(1'b1, 16'sd1, -16'sd1, -32'sd23592960, 32'hFFFFFFFF, 32'sd0, 32'hFFFFFFFF);
      drain();
      write_reg(CSR_DISTANCE, 31'h7FFFFFFF);
      write_reg(CSR_PITCH_FLOOR, 31'(24'sd5898240));
      write_reg(CSR_PITCH_CEIL, 31'(-24'sd5898240));
      // crossed limits, huge distance: saturation of offsets and camera
      add_frame(1'b1, 16'sd50, 16'sh7FFF, 32'sd0, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh80000000);
      add_frame(1'b1, -16'sd50, 16'sh8000, 32'sd5898240, 32'sh80000000, 32'sh80000000,
                32'sh7FFFFFFF);
      add_frame(1'b0, 16'sd0, 16'sd0, 32'sd11796480, 32'sd0, 32'sd0, 32'sd0);
      drain();
      write_reg(CSR_DISTANCE, 31'd0);
      write_reg(CSR_PITCH_FLOOR, 31'(-24'sd5898240));
      write_reg(CSR_PITCH_CEIL, 31'(24'sd5898240));
      add_frame(1'b1, 16'sd7, 16'sh7FFF, 32'sh12345678, 32'sd5, 32'sd6, 32'sd7);
      add_frame(1'b1, 16'sd7, 16'sh8000, 32'shEDCBA987, 32'sd5, 32'sd6, 32'sd7);
      drain();

      for (int ph = 0; ph < 8; ph++) begin
         case (ph % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 63; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 63; end
            default: begin send_idle_pct = 27; recv_stall_pct = 27; end
         endcase
         case (ph)
            0: begin
               write_reg(CSR_PITCH_FLOOR, 31'(24'sd0));
               write_reg(CSR_PITCH_CEIL, 31'(24'sd5898240));
               write_reg(CSR_DISTANCE, 31'd3276800);
            end
            3: begin
               write_reg(CSR_PITCH_FLOOR, 31'(-24'sd5898240));
               write_reg(CSR_PITCH_CEIL, 31'(24'sd5898240));
               write_reg(CSR_DISTANCE, 31'h7FFFFFFF);
            end
            5: begin
               write_reg(CSR_PITCH_FLOOR, 31'(24'sd5898240));
               write_reg(CSR_PITCH_CEIL, 31'(-24'sd5898240));
               write_reg(CSR_DISTANCE, 31'd0);
            end
            default: begin
               write_reg(CSR_PITCH_FLOOR, 31'(rand_pitch()));
               write_reg(CSR_PITCH_CEIL, 31'(rand_pitch()));
               write_reg(CSR_DISTANCE, $urandom_range(1) ? 31'($urandom()) :
                                       31'($urandom_range(20000000)));
            end
         endcase
         for (int n = 0; n < 250; n++)
            add_frame($urandom_range(4) != 0, rand_delta(), rand_delta(), $urandom(),
                      rand_pos(), rand_pos(), rand_pos());
         drain();
      end

      $display("covered %0d checked results over 8 random phases and directed corners,",
               views_checked);
      $display("with crossed pitch limits, zero and full distance, and sender/receiver stalls");
      if (errors == 0) begin
         $display("tb_orbit_camera_position: done, clean");
      end else begin
         $display("tb_orbit_camera_position: done, errors");
      end
      $finish;
   end

   initial begin
      #40000000;
      $display("timeout with %0d results outstanding", expected_views.size());
      $display("tb_orbit_camera_position: done, errors");
      $finish;
   end

endmodule
`default_nettype wire

// ===== orbit_camera_position.f =====
src/ocp_pkg.sv
src/ocp_angle.sv
src/ocp_cordic.sv
src/ocp_dp.sv
src/ocp_ctrl.sv
src/orbit_camera_position.sv
sim/tb_orbit_camera_position.sv
